[design/nau_pkg.sv]
// Package for the neural activation unit: field widths, function codes,
// and the constant sigmoid table builder. No dependencies.
package nau_pkg;

    localparam int XW        = 16;   // Q8.8 element width
    localparam int FuncW     = 3;    // function selector width
    localparam int SlopeW    = 16;   // leaky slope, unsigned Q0.16
    localparam int SigW      = 9;    // sigmoid value 0..256
    localparam int RomDepth  = 2048;
    localparam int RomAddrW  = $clog2(RomDepth);

    localparam logic [SlopeW-1:0] LeakSlopeReset = 16'd655;

    // function codes
    localparam logic [FuncW-1:0] FuncRelu     = 3'd0;
    localparam logic [FuncW-1:0] FuncReluD    = 3'd1;
    localparam logic [FuncW-1:0] FuncLeaky    = 3'd2;
    localparam logic [FuncW-1:0] FuncLeakyD   = 3'd3;
    localparam logic [FuncW-1:0] FuncSigmoid  = 3'd4;
    localparam logic [FuncW-1:0] FuncSigmoidD = 3'd5;

    localparam int FracBits = 52;

    typedef logic [RomDepth-1:0][SigW-1:0] t_sig_rom;

    // Shift-subtract division, elaboration only.
    function automatic logic [63:0] nau_udiv(input logic [127:0] num, input logic [63:0] den);
        logic [64:0]  rem;
        logic [127:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 127; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo[63:0];
    endfunction

    // (a * b) >> 52, kept to 64 bits
    function automatic logic [63:0] nau_mul_q52(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return p[FracBits+63:FracBits];
    endfunction

    // round(256 / (1 + exp(-i/256))) for i in 0..RomDepth-1, Q.52 integer math
    function automatic t_sig_rom nau_build_sig_rom();
        t_sig_rom     rom;
        logic [63:0]  one;
        logic [63:0]  term;
        logic [63:0]  step;
        logic [63:0]  y;
        logic [63:0]  d;
        logic [63:0]  q;
        logic [127:0] num;
        one  = 64'd1 << FracBits;
        term = one;
        step = one;
        y    = one;
        num  = 128'd1 << (FracBits + 9);
        // exp(-1/256) by its Taylor series
        for (int n = 1; n <= 8; n++) begin
            term = nau_udiv(128'(term), 64'(256 * n));
            if ((n % 2) == 1) begin
                step = step - term;
            end else begin
                step = step + term;
            end
        end
        for (int i = 0; i < RomDepth; i++) begin
            d      = one + y;
            q      = nau_udiv(num, d);
            rom[i] = SigW'((q + 64'd1) >> 1);
            y      = nau_mul_q52(y, step);
        end
        return rom;
    endfunction

endpackage

[design/nau_sig_rom.sv]
// Sigmoid ROM over |x| with registered read data.
// Depends on nau_pkg for the table builder and widths.
module nau_sig_rom (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [nau_pkg::RomAddrW-1:0] i_addr,
    output logic [nau_pkg::SigW-1:0]     o_data
);
    import nau_pkg::*;

    localparam t_sig_rom SigRom = nau_build_sig_rom();

    logic [SigW-1:0] r_data;

    // registered read, held while the stage stalls
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SigRom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

[design/neural_activation_unit.sv]
// Top level of the neural activation unit: four-stage pipeline around the
// sigmoid ROM and the leaky multiplier. Depends on nau_pkg and nau_sig_rom.
//
// Element-wise activation on signed Q8.8 values. Each stream transaction
// carries one element in s_axis_tdata and the function code in
// s_axis_tuser (ReLU, leaky ReLU, sigmoid and their derivatives); one
// result leaves on the master side for each. The unit takes one element
// per clock cycle unless m_axis_tready holds it, and each result passes
// four register stages: input decode, ROM read and slope multiply,
// sigmoid derivative multiply, output register. Back-pressure on
// m_axis_tready holds the pipeline, and empty stages still fill while the
// output waits. The leaky slope is set through i_cfg_wr_en / i_cfg_wr_data
// and must only change while no element is in flight. The sigmoid table is
// constant, so the unit is ready right after reset.
module neural_activation_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: leak_slope, unsigned Q0.16
    input  logic                        i_cfg_wr_en,
    input  logic [nau_pkg::SlopeW-1:0]  i_cfg_wr_data,
    // input stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [15:0] x_value
    input  logic [2:0]                  s_axis_tuser,   // [2:0] func
    // output stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [15:0]                 m_axis_tdata    // [15:0] y_value
);
    import nau_pkg::*;

    logic [SlopeW-1:0] r_leak_slope;

    // stage valids and per-stage load enables
    logic r1_v, r2_v, r3_v, r4_v;
    logic en1, en2, en3, en4;

    // stage 1 registers
    logic [FuncW-1:0] r1_func;
    logic [XW-1:0]    r1_x;
    logic             r1_pos;
    logic             r1_neg;
    logic [XW-1:0]    r1_mag;

    // stage 2 registers
    logic [FuncW-1:0]    r2_func;
    logic [XW-1:0]       r2_x;
    logic                r2_pos;
    logic                r2_neg;
    logic                r2_big;
    logic [2*XW-1:0]     r2_prod;
    logic [SigW-1:0]     rom_data;

    // stage 3 registers
    logic [FuncW-1:0]    r3_func;
    logic [XW-1:0]       r3_x;
    logic                r3_pos;
    logic [SigW-1:0]     r3_s;
    logic [2*SigW-1:0]   r3_sd;
    logic [XW-1:0]       r3_leaky_neg;

    // output register
    logic [XW-1:0]       r4_y;

    // stage 1 combinational terms
    logic [XW-1:0]       n1_mag;
    // stage 3 combinational terms
    logic [SigW-1:0]     s_mag;
    logic [SigW-1:0]     s_val;
    logic [XW:0]         leak_ceil;
    // stage 4 selection
    logic [XW-1:0]       n4_y;

    // a stage loads when it is empty or its contents move on
    assign en4 = !r4_v || m_axis_tready;
    assign en3 = !r3_v || en4;
    assign en2 = !r2_v || en3;
    assign en1 = !r1_v || en2;
    assign s_axis_tready = en1;

    // leaky slope register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leak_slope <= LeakSlopeReset;
        end else if (i_cfg_wr_en) begin
            r_leak_slope <= i_cfg_wr_data;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (en1) r1_v <= s_axis_tvalid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
        end
    end

    // stage 1: sign and magnitude
    assign n1_mag = s_axis_tdata[XW-1] ? (~s_axis_tdata + 16'd1) : s_axis_tdata;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_func <= s_axis_tuser;
            r1_x    <= s_axis_tdata;
            r1_neg  <= s_axis_tdata[XW-1];
            r1_pos  <= !s_axis_tdata[XW-1] && (s_axis_tdata != '0);
            r1_mag  <= n1_mag;
        end
    end

    // stage 2: ROM read and slope product alpha * |x|
    nau_sig_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (en2),
        .i_addr (r1_mag[RomAddrW-1:0]),
        .o_data (rom_data)
    );

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_func <= r1_func;
            r2_x    <= r1_x;
            r2_pos  <= r1_pos;
            r2_neg  <= r1_neg;
            r2_big  <= |r1_mag[XW-1:RomAddrW];
            r2_prod <= (2*XW)'(r_leak_slope) * (2*XW)'(r1_mag);
        end
    end

    // stage 3: signed sigmoid, its derivative product, leaky ceiling
    assign s_mag     = r2_big ? 9'd256 : rom_data;
    assign s_val     = r2_neg ? (9'd256 - s_mag) : s_mag;
    assign leak_ceil = (XW+1)'((33'(r2_prod) + 33'd65535) >> 16);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_func      <= r2_func;
            r3_x         <= r2_x;
            r3_pos       <= r2_pos;
            r3_s         <= s_val;
            r3_sd        <= (2*SigW)'(s_val) * (2*SigW)'(9'd256 - s_val);
            r3_leaky_neg <= XW'(17'd0 - leak_ceil);
        end
    end

    // stage 4: result select
    always_comb begin
        unique case (r3_func)
            FuncRelu:     n4_y = r3_pos ? r3_x : '0;
            FuncReluD:    n4_y = r3_pos ? 16'd256 : '0;
            FuncLeaky:    n4_y = r3_pos ? r3_x : r3_leaky_neg;
            FuncLeakyD:   n4_y = r3_pos ? 16'd256 : {8'd0, r_leak_slope[15:8]};
            FuncSigmoid:  n4_y = {7'd0, r3_s};
            FuncSigmoidD: n4_y = XW'(r3_sd >> 8);
            default:      n4_y = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_y <= n4_y;
        end
    end

    assign m_axis_tvalid = r4_v;
    assign m_axis_tdata  = r4_y;

endmodule

[design/nau_checker.sv]
// Port-level checker for the neural activation unit, bound to the top level.
// Depends on nau_pkg for the function codes.
module nau_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_wr_en,
    input logic [nau_pkg::SlopeW-1:0]  i_cfg_wr_data,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [15:0]                 s_axis_tdata,
    input logic [2:0]                  s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [15:0]                 m_axis_tdata
);
    import nau_pkg::*;

    logic in_acc;
    logic relu_d_pos;
    logic sig_zero;
    logic clear_run;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign relu_d_pos = in_acc && (s_axis_tuser == FuncReluD) && !s_axis_tdata[15]
                        && (s_axis_tdata != 16'd0);
    assign sig_zero   = in_acc && (s_axis_tuser == FuncSigmoid) && (s_axis_tdata == 16'd0);
    // output side ready and not in reset
    assign clear_run  = m_axis_tready && i_rst_n;

    // a result waiting on the output stays
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transaction dropped or changed while stalled");

    // ReLU derivative of a positive element is 1.0 when the output side stays ready
    a_relu_d: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(relu_d_pos, 4) && $past(i_rst_n, 4)
        && $past(clear_run, 3) && $past(clear_run, 2) && $past(clear_run, 1)
        |-> m_axis_tvalid && (m_axis_tdata == 16'd256))
        else $error("relu derivative result missing or wrong");

    // sigmoid at zero is one half when the output side stays ready
    a_sig_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(sig_zero, 4) && $past(i_rst_n, 4)
        && $past(clear_run, 3) && $past(clear_run, 2) && $past(clear_run, 1)
        |-> m_axis_tvalid && (m_axis_tdata == 16'd128))
        else $error("sigmoid of zero result missing or wrong");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind neural_activation_unit nau_checker u_nau_checker (.*);

[tb/sv/neural_activation_unit_tb.sv]
// Self-checking testbench for neural_activation_unit: a scoreboard class predicts
// every result from its own sigmoid table and leaky slope copy.
// Depends on nau_pkg and the neural_activation_unit RTL.
module neural_activation_unit_tb;

    import nau_pkg::*;

    localparam int PipeLatency   = 4;
    localparam int LongStall     = 60;
    localparam int WatchdogLimit = 2000;
    localparam int PhaseItems    = 100;

    // selector codes with no operation behind them
    localparam logic [FuncW-1:0] FuncSpareA = 3'd6;
    localparam logic [FuncW-1:0] FuncSpareB = 3'd7;

    typedef struct {
        logic [FuncW-1:0] func;
        logic [XW-1:0]    x_value;
        logic [XW-1:0]    y_value;
    } t_act_expect;

    // Predicts each activation result and checks results in order.
    class activation_scoreboard;
        logic [SigW-1:0]   sig_table [RomDepth];
        logic [SlopeW-1:0] leak_slope;
        t_act_expect       pending_y [$];
        int                errors;

        function new();
            leak_slope = LeakSlopeReset;
            errors     = 0;
            build_sigmoid_table();
        endfunction

        // round(256 / (1 + exp(-i/256))) in Q.52 integer arithmetic
        function void build_sigmoid_table();
            logic [63:0]  one;
            logic [63:0]  term;
            logic [63:0]  decay;
            logic [63:0]  ex;
            logic [63:0]  den;
            logic [63:0]  quo;
            logic [127:0] prod;
            one   = 64'd1 << 52;
            term  = one;
            decay = one;
            ex    = one;
            // exp(-1/256) from its Taylor series
            for (int n = 1; n <= 8; n++) begin
                term = term / 64'(256 * n);
                if ((n % 2) == 1) begin
                    decay = decay - term;
                end else begin
                    decay = decay + term;
                end
            end
            for (int i = 0; i < RomDepth; i++) begin
                den          = one + ex;
                quo          = (64'd1 << 61) / den;
                sig_table[i] = SigW'((quo + 64'd1) >> 1);
                prod         = 128'(ex) * 128'(decay);
                ex           = prod[115:52];
            end
        endfunction

        function void set_slope(logic [SlopeW-1:0] value);
            leak_slope = value;
        endfunction

        // symmetric table lookup, saturated beyond the table
        function int sigmoid_of(int x);
            int mag;
            int s;
            mag = (x < 0) ? -x : x;
            s   = (mag >= RomDepth) ? 256 : int'(sig_table[mag]);
            return (x < 0) ? 256 - s : s;
        endfunction

        function logic [XW-1:0] predict(logic [FuncW-1:0] func, logic signed [XW-1:0] x_value);
            int              x;
            int              y;
            int              s;
            longint unsigned m;
            x = x_value;
            case (func)
                FuncRelu: begin
                    y = (x > 0) ? x : 0;
                end
                FuncReluD: begin
                    y = (x > 0) ? 256 : 0;
                end
                FuncLeaky: begin
                    if (x > 0) begin
                        y = x;
                    end else begin
                        // floor of a negative product: negate the ceiling of the magnitude
                        m = longint'(leak_slope) * longint'(-x);
                        y = -int'((m + 65535) >> 16);
                    end
                end
                FuncLeakyD: begin
                    y = (x > 0) ? 256 : int'(leak_slope >> 8);
                end
                FuncSigmoid: begin
                    y = sigmoid_of(x);
                end
                FuncSigmoidD: begin
                    s = sigmoid_of(x);
                    y = (s * (256 - s)) >> 8;
                end
                default: begin
                    y = 0;
                end
            endcase
            return XW'(y);
        endfunction

        function void note_input(logic [FuncW-1:0] func, logic [XW-1:0] x_value);
            t_act_expect e;
            e.func    = func;
            e.x_value = x_value;
            e.y_value = predict(func, x_value);
            pending_y.push_back(e);
        endfunction

        function void check_result(logic [XW-1:0] y_value);
            t_act_expect e;
            if (pending_y.size() == 0) begin
                errors++;
                $display("%0t: unexpected result y_value=%h", $time, y_value);
            end else begin
                e = pending_y.pop_front();
                if (y_value !== e.y_value) begin
                    errors++;
                    $display("%0t: y_value mismatch func=%0d x=%h expected=%h actual=%h",
                             $time, e.func, e.x_value, e.y_value, y_value);
                end
            end
        endfunction

        function int pending();
            return pending_y.size();
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_wr_en;
    logic [SlopeW-1:0]    i_cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [15:0]          s_axis_tdata;   // [15:0] x_value
    logic [2:0]           s_axis_tuser;   // [2:0] func
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [15:0]          m_axis_tdata;   // [15:0] y_value

    activation_scoreboard sb;
    bit                   idle_en;
    bit                   stall_request;

    neural_activation_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock, period 8
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // one input transaction, with an optional idle burst ahead of it
    task automatic send_item(input logic [FuncW-1:0] func, input logic [XW-1:0] x_value);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= x_value;
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(func, x_value);
        @(negedge i_clk);
    endtask

    // drain the pipeline, then write the leak slope while idle
    task automatic write_slope(input logic [SlopeW-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (PipeLatency) @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_slope(value);
    endtask

    // mostly the sigmoid domain and the edges, plus full-range values
    function automatic logic [XW-1:0] rand_x();
        logic [XW-1:0] edges [11];
        edges = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'd2047,
                  16'd2048, -16'sd2047, -16'sd2048, 16'd1597, -16'sd1597};
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return XW'($urandom);
            4, 5, 6:    return XW'(int'($urandom_range(0, 4200)) - 2100);
            7:          return XW'(int'($urandom_range(0, 32)) - 16);
            8:          return edges[$urandom_range(0, 10)];
            default:    return XW'(int'($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    function automatic logic [FuncW-1:0] rand_func();
        if ($urandom_range(0, 15) < 14) begin
            return FuncW'($urandom_range(0, 5));
        end
        return ($urandom_range(0, 1) == 0) ? FuncSpareA : FuncSpareB;
    endfunction

    task automatic random_items(input int count, input bit with_pressure);
        for (int i = 0; i < count; i++) begin
            if (with_pressure && i == count / 2) begin
                stall_request = 1'b1;
            end
            send_item(rand_func(), rand_x());
        end
    endtask

    // receiver: random idle bursts, one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LongStall) @(negedge i_clk);
            end else if (idle_en && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
        end
    end

    // watchdog: cycles without any transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WatchdogLimit) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    // main sequence
    initial begin
        logic [XW-1:0] corner [3];
        sb            = new();
        idle_en       = 1'b1;
        stall_request = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every selector, including the unused ones, at zero and both extremes
        corner = '{16'h0000, 16'h8000, 16'h7fff};
        for (int f = 0; f < 8; f++) begin
            foreach (corner[k]) begin
                send_item(FuncW'(f), corner[k]);
            end
        end
        // last sigmoid table entry, just short of the saturated range
        send_item(FuncSigmoid, 16'd2047);

        // random phases over several slopes, both extremes included
        write_slope(16'd0);
        random_items(PhaseItems, 1'b0);
        write_slope(16'hffff);
        random_items(PhaseItems, 1'b1);
        write_slope(SlopeW'($urandom_range(0, 65535)));
        random_items(PhaseItems, 1'b0);
        write_slope(16'h8000);
        random_items(PhaseItems, 1'b0);
        write_slope(16'd1);
        random_items(PhaseItems, 1'b0);
        write_slope(LeakSlopeReset);
        idle_en = 1'b0;
        random_items(PhaseItems, 1'b0);

        // drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2 * PipeLatency) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d results never arrived", $time, sb.pending());
        end
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
